>>> rtl/core/bpbb_pkg.sv
// Package for the beat position to bar and beat converter.
// Holds payload structs, opcodes, state codes and fixed widths; no dependencies.
package bpbb_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned NumW   = 8;
  localparam int unsigned DlogW  = 3;
  localparam int unsigned BarW   = 16;
  localparam int unsigned BeatW  = 25;
  localparam int unsigned CountW = 4;

  // Signed accumulator widths: timestamp and section length with sign,
  // scaled value up to 2^39, divisor up to 255 * 2^18.
  localparam int unsigned TW   = 34;
  localparam int unsigned SclW = 42;
  localparam int unsigned DivW = 36;
  localparam int unsigned QW   = 42;
  localparam int unsigned AccW = 46;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_CONVERT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_DIV,
    ST_ACC,
    ST_LAST,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               op;
    logic [2:0]         entry_index;
    logic [PosW-1:0]    entry_position;
    logic [NumW-1:0]    entry_numerator;
    logic [DlogW-1:0]   entry_denominator_log2;
    logic [PosW-1:0]    timestamp;
  } in_item_t;

  typedef struct packed {
    logic [BarW-1:0]  bar_number;
    logic [BeatW-1:0] beat_in_bar;
    logic             is_conversion;
  } out_item_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

>>> rtl/core/beat_position_to_bar_and_beat.sv
// Beat position to bar and beat converter, top level with table and sequencer.
// Timing: a load item gives its result in the cycle after its transfer, and the next
// transfer is taken once that result has left ST_OUT; a convert does one divide per
// table section walked plus a last divide, each in the bit-serial divider (one bit a cycle).
// Throughput: one item at a time; the next is taken once the result register frees.
// Reset: table entries become 4/4 at position zero, signature_count becomes 1.
// Depends on bpbb_pkg and bpbb_div.
module beat_position_to_bar_and_beat #(
  parameter int unsigned MAX_SIGNATURES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bpbb_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bpbb_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IdxW = (MAX_SIGNATURES > 1) ? $clog2(MAX_SIGNATURES) : 1;
  localparam int unsigned CntW = $clog2(MAX_SIGNATURES + 1);
  localparam int unsigned FracB = 16;

  typedef logic signed [bpbb_pkg::TW-1:0]   t_t;
  typedef logic signed [bpbb_pkg::AccW-1:0] acc_t;

  logic [bpbb_pkg::CountW-1:0] count_q;
  logic [bpbb_pkg::PosW-1:0]   pos_q  [MAX_SIGNATURES];
  logic [bpbb_pkg::NumW-1:0]   num_q  [MAX_SIGNATURES];
  logic [bpbb_pkg::DlogW-1:0]  dlog_q [MAX_SIGNATURES];

  bpbb_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  i_q, i_d;
  logic [CntW-1:0]  lim_q, lim_d;
  t_t               t_q, t_d;
  t_t               last_q, last_d;
  t_t               diff_q, diff_d;
  logic [bpbb_pkg::NumW-1:0]  cn_q, cn_d;
  logic [bpbb_pkg::DlogW-1:0] cd_q, cd_d;
  acc_t             bars_q, bars_d;
  logic             neg_q, neg_d;
  logic             ov_q, ov_d;
  bpbb_pkg::out_item_t res_q, res_d;

  logic [IdxW-1:0]  ridx;
  logic [bpbb_pkg::PosW-1:0]  rpos;
  t_t               ediff;
  logic [bpbb_pkg::SclW-1:0]  mag;
  logic [bpbb_pkg::SclW-1:0]  dvd;
  logic [bpbb_pkg::DivW-1:0]  dvs;
  bpbb_pkg::div_ctl_t dctl;
  bpbb_pkg::div_sts_t dsts;
  logic [bpbb_pkg::QW-1:0]    quo;
  logic [bpbb_pkg::DivW-1:0]  rem;
  logic [bpbb_pkg::NumW-1:0]  neff;
  logic             accept, wr_en;
  acc_t             qterm;
  acc_t             fin;
  logic [bpbb_pkg::DivW-1:0]  beatv;
  logic [CntW:0]    cnt_ext;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(count_q) : '0;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == 1'b0);

  assign in_stall_o  = (state_q != bpbb_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == bpbb_pkg::ST_OUT);
  assign out_data_o  = res_q;

  assign ridx  = i_q[IdxW-1:0];
  assign rpos  = pos_q[ridx];
  assign ediff = t_t'({1'b0, rpos}) - last_q;

  assign neff = (cn_q == '0) ? bpbb_pkg::NumW'(1) : cn_q;
  assign dvs  = bpbb_pkg::DivW'({neff, {(FracB + 2){1'b0}}});
  // Magnitude of the (possibly negative) value scaled by the note value.
  assign mag  = neg_q ? bpbb_pkg::SclW'(-diff_q) : bpbb_pkg::SclW'(diff_q);
  assign dvd  = mag << cd_q;

  assign cnt_ext = (32'(count_q) > 32'(MAX_SIGNATURES))
                   ? (CntW + 1)'(MAX_SIGNATURES) : (CntW + 1)'(count_q);

  bpbb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (dctl),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .sts_o      (dsts),
    .quot_o     (quo),
    .rem_o      (rem)
  );

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    lim_d   = lim_q;
    t_d     = t_q;
    last_d  = last_q;
    diff_d  = diff_q;
    cn_d    = cn_q;
    cd_d    = cd_q;
    bars_d  = bars_q;
    neg_d   = neg_q;
    ov_d    = ov_q;
    res_d   = res_q;
    dctl.start = 1'b0;
    qterm   = acc_t'(quo);
    fin     = bars_q + qterm + acc_t'(1);
    beatv   = (rem >> 2) + bpbb_pkg::DivW'(1 << FracB);
    unique case (state_q)
      bpbb_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data_i.op == bpbb_pkg::OP_LOAD) begin
            res_d   = '0;
            state_d = bpbb_pkg::ST_OUT;
          end else begin
            t_d     = t_t'({1'b0, in_data_i.timestamp});
            last_d  = '0;
            cn_d    = bpbb_pkg::NumW'(4);
            cd_d    = bpbb_pkg::DlogW'(2);
            bars_d  = '0;
            i_d     = '0;
            lim_d   = CntW'(cnt_ext);
            state_d = bpbb_pkg::ST_CHECK;
          end
        end
      end
      bpbb_pkg::ST_CHECK: begin
        if (i_q == lim_q || (t_q - ediff) < 0) begin
          diff_d  = t_q;
          neg_d   = 1'b0;
          state_d = bpbb_pkg::ST_LAST;
        end else begin
          diff_d  = ediff;
          neg_d   = ediff[bpbb_pkg::TW-1];
          t_d     = t_q - ediff;
          state_d = bpbb_pkg::ST_FETCH;
        end
      end
      bpbb_pkg::ST_FETCH: begin
        dctl.start = 1'b1;
        state_d    = bpbb_pkg::ST_DIV;
      end
      bpbb_pkg::ST_DIV: begin
        if (dsts.done) begin
          state_d = bpbb_pkg::ST_ACC;
        end
      end
      bpbb_pkg::ST_ACC: begin
        if (neg_q) begin
          bars_d = bars_q - acc_t'(quo);
        end else begin
          bars_d = bars_q + acc_t'(quo) + acc_t'(rem != '0);
        end
        last_d  = t_t'({1'b0, rpos});
        cn_d    = num_q[ridx];
        cd_d    = dlog_q[ridx];
        i_d     = i_q + 1'b1;
        state_d = bpbb_pkg::ST_CHECK;
      end
      bpbb_pkg::ST_LAST: begin
        if (!ov_q) begin
          dctl.start = 1'b1;
          ov_d       = 1'b1;
        end else if (dsts.done) begin
          ov_d = 1'b0;
          res_d.is_conversion = 1'b1;
          res_d.beat_in_bar   = bpbb_pkg::BeatW'(beatv);
          if (fin < 0) begin
            res_d.bar_number = '0;
          end else if (fin > acc_t'(65535)) begin
            res_d.bar_number = 16'hFFFF;
          end else begin
            res_d.bar_number = fin[bpbb_pkg::BarW-1:0];
          end
          state_d = bpbb_pkg::ST_OUT;
        end
      end
      bpbb_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          state_d = bpbb_pkg::ST_IDLE;
        end
      end
      default: state_d = bpbb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpbb_pkg::ST_IDLE;
      count_q <= bpbb_pkg::CountW'(1);
      ov_q    <= 1'b0;
      i_q     <= '0;
      lim_q   <= '0;
      for (int k = 0; k < MAX_SIGNATURES; k++) begin
        pos_q[k]  <= '0;
        num_q[k]  <= bpbb_pkg::NumW'(4);
        dlog_q[k] <= bpbb_pkg::DlogW'(2);
      end
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      i_q     <= i_d;
      lim_q   <= lim_d;
      if (wr_en) begin
        count_q <= pwdata[bpbb_pkg::CountW-1:0];
      end
      if (accept && in_data_i.op == bpbb_pkg::OP_LOAD &&
          32'(in_data_i.entry_index) < 32'(MAX_SIGNATURES)) begin
        pos_q[IdxW'(in_data_i.entry_index)]  <= in_data_i.entry_position;
        num_q[IdxW'(in_data_i.entry_index)]  <= in_data_i.entry_numerator;
        dlog_q[IdxW'(in_data_i.entry_index)] <= in_data_i.entry_denominator_log2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    last_q <= last_d;
    diff_q <= diff_d;
    cn_q   <= cn_d;
    cd_q   <= cd_d;
    bars_q <= bars_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

endmodule

>>> rtl/core/bpbb_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bpbb_pkg for widths and control structs.
module bpbb_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpbb_pkg::div_ctl_t            ctl_i,
  input  logic [bpbb_pkg::SclW-1:0]     dividend_i,
  input  logic [bpbb_pkg::DivW-1:0]     divisor_i,
  output bpbb_pkg::div_sts_t            sts_o,
  output logic [bpbb_pkg::QW-1:0]       quot_o,
  output logic [bpbb_pkg::DivW-1:0]     rem_o
);

  localparam int unsigned CntW = $clog2(bpbb_pkg::SclW + 1);

  logic [bpbb_pkg::QW-1:0]   q_q, q_d;
  logic [bpbb_pkg::DivW:0]   r_q, r_d;
  logic [bpbb_pkg::DivW-1:0] dv_q, dv_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic [bpbb_pkg::DivW:0]   trial;
  logic [bpbb_pkg::DivW:0]   diff;

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    dv_d   = dv_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {r_q[bpbb_pkg::DivW-1:0], q_q[bpbb_pkg::QW-1]};
    diff   = trial - {1'b0, dv_q};
    if (ctl_i.start) begin
      q_d    = dividend_i;
      r_d    = '0;
      dv_d   = divisor_i;
      cnt_d  = CntW'(bpbb_pkg::SclW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[bpbb_pkg::DivW]) begin
        r_d = diff;
        q_d = {q_q[bpbb_pkg::QW-2:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[bpbb_pkg::QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    r_q  <= r_d;
    dv_q <= dv_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = q_q;
  assign rem_o      = r_q[bpbb_pkg::DivW-1:0];

endmodule
